>>> hw/rtl/vfag_pkg.sv
// Vertex fetch address generator package: register indexes, field widths,
// microcode control word and the microprogram ROM. No dependencies.
package vfag_pkg;

  localparam int unsigned SLOTS_DEF        = 4;
  localparam int unsigned MAX_ELEMENTS_DEF = 8;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned ELEM_W  = 3;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COMP_W  = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned EOFF_W  = 8;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned STEP_W  = 2;

  localparam int unsigned IN_DATA_W  = ID_W;
  localparam int unsigned OUT_DATA_W = ID_W + ELEM_W + SLOT_W + ADDR_W + COMP_W;

  localparam logic [COMP_W-1:0] COMP_MAX = 3'd4;

  typedef enum logic [2:0] {
    REG_ELEMENT_COUNT     = 3'd0,
    REG_INDEXED_MODE      = 3'd1,
    REG_INDEX_BYTES       = 3'd2,
    REG_SLOT_STRIDES      = 3'd3,
    REG_SLOT_OFFSETS      = 3'd4,
    REG_ELEMENT_DESC_LOW  = 3'd5,
    REG_ELEMENT_DESC_HIGH = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JC_NONE       = 2'd0,
    JC_COUNT_ZERO = 2'd1,
    JC_MORE       = 2'd2
  } jcond_e;

  localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
  localparam logic [STEP_W-1:0] STEP_MUL   = 2'd1;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd2;

  typedef struct packed {
    logic              wait_in;
    logic              wait_out;
    logic              load_id;
    logic              mul_first;
    logic              mul_next;
    logic              emit;
    jcond_e            cond;
    logic [STEP_W-1:0] jump_to;
    logic [STEP_W-1:0] next_to;
  } ucode_t;

  typedef struct packed {
    logic              load_id;
    logic              mul_first;
    logic              mul_next;
    logic              emit;
    logic [STEP_W-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic count_zero;
    logic elem_last;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc = '{wait_in: 1'b0, wait_out: 1'b0, load_id: 1'b0, mul_first: 1'b0,
           mul_next: 1'b0, emit: 1'b0, cond: JC_NONE,
           jump_to: STEP_FETCH, next_to: STEP_FETCH};
    case (step)
      STEP_FETCH: begin
        uc.wait_in = 1'b1;
        uc.load_id = 1'b1;
        uc.cond    = JC_COUNT_ZERO;
        uc.jump_to = STEP_FETCH;
        uc.next_to = STEP_MUL;
      end
      STEP_MUL: begin
        uc.mul_first = 1'b1;
        uc.next_to   = STEP_EMIT;
      end
      STEP_EMIT: begin
        uc.wait_out = 1'b1;
        uc.emit     = 1'b1;
        uc.mul_next = 1'b1;
        uc.cond     = JC_MORE;
        uc.jump_to  = STEP_EMIT;
        uc.next_to  = STEP_FETCH;
      end
      default: begin
        uc.next_to = STEP_FETCH;
      end
    endcase
    return uc;
  endfunction

endpackage

>>> hw/rtl/vertex_fetch_address_generator.sv
// Vertex fetch address generator top level: configuration registers, id and
// address datapath, output register. Depends on vfag_pkg and vfag_sequencer.
//
// One vertex is taken per input transaction and yields one fetch request per
// layout element (none when element_count is zero). A vertex passes through
// the fetch step, which takes the vertex and forms its id, the multiply step,
// which forms the first id * stride product in the single 32x16 multiplier,
// and the emit step, which gives one request per cycle while the output side
// does not stall and the multiplier works on the next element. Each request
// sits in an output register; the next vertex is taken once the last request
// of the current one has been loaded there. Configuration writes are always
// ready and take effect on the next cycle.
module vertex_fetch_address_generator #(
  parameter int unsigned SLOTS        = vfag_pkg::SLOTS_DEF,
  parameter int unsigned MAX_ELEMENTS = vfag_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [vfag_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // index_word [31:0]
  input  logic [vfag_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // first_of_draw [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // vertex_id [31:0], element_index [34:32], buffer_slot [36:35],
  // byte_address [68:37], components [71:69]
  output logic [vfag_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);
  import vfag_pkg::*;

  // configuration
  logic [CNT_W-1:0]     element_count_q;
  logic                 indexed_mode_q;
  logic [2:0]           index_bytes_q;
  logic [CFG_W-1:0]     strides_q, offsets_q, desc_low_q, desc_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= 4'd1;
      indexed_mode_q  <= 1'b0;
      index_bytes_q   <= 3'd4;
      strides_q       <= '0;
      offsets_q       <= '0;
      desc_low_q      <= '0;
      desc_high_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ELEMENT_COUNT:     element_count_q <= cfg_data_i[CNT_W-1:0];
        REG_INDEXED_MODE:      indexed_mode_q  <= cfg_data_i[0];
        REG_INDEX_BYTES:       index_bytes_q   <= cfg_data_i[2:0];
        REG_SLOT_STRIDES:      strides_q       <= cfg_data_i;
        REG_SLOT_OFFSETS:      offsets_q       <= cfg_data_i;
        REG_ELEMENT_DESC_LOW:  desc_low_q      <= cfg_data_i;
        REG_ELEMENT_DESC_HIGH: desc_high_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer
  ctrl_t   ctrl;
  status_t status;
  logic    out_valid_q;
  logic    out_busy;

  assign out_busy = out_valid_q && !m_axis_tready;

  vfag_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // vertex id
  logic [ID_W-1:0] vcount_q, vcount_d, id_q, id_d, cnt_base, idx_mask;

  always_comb begin
    case (index_bytes_q)
      3'd0:    idx_mask = 32'h0000_0000;
      3'd1:    idx_mask = 32'h0000_00FF;
      3'd2:    idx_mask = 32'h0000_FFFF;
      3'd3:    idx_mask = 32'h00FF_FFFF;
      default: idx_mask = 32'hFFFF_FFFF;
    endcase
    cnt_base = s_axis_tuser ? '0 : vcount_q;
    if (indexed_mode_q) begin
      id_d     = s_axis_tdata & idx_mask;
      vcount_d = cnt_base;
    end else begin
      id_d     = cnt_base;
      vcount_d = cnt_base + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      id_q     <= '0;
    end else if (ctrl.load_id) begin
      vcount_q <= vcount_d;
      id_q     <= id_d;
    end
  end

  // element count, clamped
  logic [CNT_W-1:0] count_eff;
  assign count_eff = (element_count_q > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                            : element_count_q;

  // multiply stage
  logic [ELEM_W-1:0]      pelem_q, mul_idx;
  logic [SLOT_W-1:0]      pslot_q, mslot;
  logic [COMP_W-1:0]      pcomp_q, mcomp;
  logic [EOFF_W-1:0]      poff_q;
  logic [ID_W-1:0]        product_q;
  logic [2*CFG_W-1:0]     desc_all;
  logic [FIELD_W-1:0]     mdesc, mstride;

  assign desc_all = {desc_high_q, desc_low_q};
  assign mul_idx  = ctrl.mul_next ? pelem_q + ELEM_W'(1) : '0;
  assign mdesc    = desc_all[{mul_idx, 4'b0000} +: FIELD_W];

  always_comb begin
    mslot = mdesc[1:0];
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, mslot} >= 3'(SLOTS)) begin
        mslot = SLOT_W'({1'b0, mslot} - 3'(SLOTS));
      end
    end
    mcomp = (mdesc[4:2] > COMP_MAX) ? '0 : mdesc[4:2];
  end

  assign mstride = strides_q[{mslot, 4'b0000} +: FIELD_W];

  always_ff @(posedge clk_i) begin
    if (ctrl.mul_first || ctrl.mul_next) begin
      pelem_q   <= mul_idx;
      pslot_q   <= mslot;
      pcomp_q   <= mcomp;
      poff_q    <= mdesc[12:5];
      product_q <= id_q * {16'b0, mstride};
    end
  end

  assign status.count_zero = (count_eff == '0);
  assign status.elem_last  = ({1'b0, pelem_q} + CNT_W'(1) == count_eff);

  // output register
  logic [ADDR_W-1:0]     addr;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  assign addr = product_q + {16'b0, offsets_q[{pslot_q, 4'b0000} +: FIELD_W]}
                + {24'b0, poff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= {pcomp_q, addr, pslot_q, pelem_q, id_q};
      out_last_q <= status.elem_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> ({1'b0, pelem_q} < count_eff))
    else $error("request for element beyond count");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> !out_busy)
    else $error("pending request overwritten");

  a_take_next_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=>
      (ctrl.step == STEP_MUL) || (ctrl.step == STEP_FETCH))
    else $error("bad step after vertex accepted");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && status.elem_last) |=> (ctrl.step == STEP_FETCH))
    else $error("sequencer did not return after last request");

  a_ready_only_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (ctrl.step == STEP_FETCH))
    else $error("input ready outside fetch step");

endmodule

>>> hw/rtl/vfag_sequencer.sv
// Microcode sequencer: step counter, microprogram ROM lookup, stall and
// conditional jump logic. Depends on vfag_pkg.
module vfag_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_busy_i,
  input  vfag_pkg::status_t status_i,
  output logic              in_ready_o,
  output vfag_pkg::ctrl_t   ctrl_o
);
  import vfag_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              go;
  logic              taken;

  assign uc = ucode_rom(step_q);
  assign go = !(uc.wait_in && !in_valid_i) && !(uc.wait_out && out_busy_i);

  always_comb begin
    case (uc.cond)
      JC_COUNT_ZERO: taken = status_i.count_zero;
      JC_MORE:       taken = !status_i.elem_last;
      default:       taken = 1'b0;
    endcase
    step_d = step_q;
    if (go) begin
      step_d = taken ? uc.jump_to : uc.next_to;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o       = uc.wait_in;
  assign ctrl_o.load_id   = uc.load_id & go;
  assign ctrl_o.mul_first = uc.mul_first & go;
  assign ctrl_o.mul_next  = uc.mul_next & go;
  assign ctrl_o.emit      = uc.emit & go;
  assign ctrl_o.step      = step_q;

endmodule
